/* rtl/spims_pkg.sv */
// Shared types and constants for the SPI master byte shifter.
// Used by spims_engine and spi_master_byte_shifter_core; no dependencies.
package spims_pkg;

   // Width of the interval tick counter and of the half period register.
   localparam int DividerWidth = 10;
   localparam logic [DividerWidth-1:0] HalfPeriodReset = DividerWidth'(50);

   // Command codes carried in the opcode field.
   localparam logic [2:0] OP_IDLE     = 3'd0;
   localparam logic [2:0] OP_EXCHANGE = 3'd1;
   localparam logic [2:0] OP_READ     = 3'd2;
   localparam logic [2:0] OP_SELECT   = 3'd3;
   localparam logic [2:0] OP_DESELECT = 3'd4;

   // Configuration register indexes.
   localparam int CsrIndexWidth = 2;
   localparam logic [CsrIndexWidth-1:0] CSR_SPI_MODE    = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_HALF_PERIOD = 2'd1;

   // Interval phases within one bit.
   localparam logic [1:0] PHASE_FIRST  = 2'd0;
   localparam logic [1:0] PHASE_SECOND = 2'd1;
   localparam logic [1:0] PHASE_LAST   = 2'd2;

   // Byte sent by a read command.
   localparam logic [7:0] READ_FILL = 8'hFF;

   // One input word, unpacked.
   typedef struct packed {
      logic [2:0] opcode;
      logic [7:0] tx_byte;
      logic       miso;
   } req_item_type;

   // One result word, unpacked.
   typedef struct packed {
      logic       sck;
      logic       mosi;
      logic       cs_n;
      logic [7:0] rx_byte;
      logic       rx_valid;
      logic       busy_res;
      logic       rejected;
   } rsp_item_type;

   // A configuration write as seen by the engine.
   typedef struct packed {
      logic                     write;
      logic [CsrIndexWidth-1:0] index;
      logic [DividerWidth-1:0]  data;
   } csr_write_type;

endpackage

/* rtl/spims_engine.sv */
// Pin-level SPI engine: holds the transfer state and the configuration
// registers and advances them by one tick per consumed word. Uses spims_pkg.
module spims_engine import spims_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          step,
   input  req_item_type  item,
   input  csr_write_type csr,
   output rsp_item_type  result
);

   logic [1:0]              spi_mode_ff, spi_mode_in;
   logic [DividerWidth-1:0] half_period_ff, half_period_in;
   logic [7:0]              tx_shift_ff, tx_shift_in;
   logic [7:0]              rx_shift_ff, rx_shift_in;
   logic [2:0]              bit_index_ff, bit_index_in;
   logic [1:0]              phase_ff, phase_in;
   logic [DividerWidth-1:0] tick_count_ff, tick_count_in;
   logic                    sck_ff, sck_in;
   logic                    mosi_ff, mosi_in;
   logic                    cs_ff, cs_in;
   logic                    busy_ff, busy_in;
   logic                    sel_delay_ff, sel_delay_in;

   logic [DividerWidth-1:0] half_period_eff;
   logic [DividerWidth:0]   tick_next;
   logic [2:0]              phase_step;
   logic [3:0]              bit_step;
   logic                    start_en;
   logic                    cpol;
   logic                    cpha;
   logic                    cmd_valid;
   logic                    rejected;
   logic                    rx_valid;
   logic [7:0]              rx_out;

   assign cpol = spi_mode_ff[1];
   assign cpha = spi_mode_ff[0];
   assign cmd_valid = (item.opcode == OP_EXCHANGE) || (item.opcode == OP_READ) ||
                      (item.opcode == OP_SELECT) || (item.opcode == OP_DESELECT);
   // A zero interval length behaves as one tick.
   assign half_period_eff = (half_period_ff == '0) ? DividerWidth'(1) : half_period_ff;
   assign tick_next = {1'b0, tick_count_ff} + (DividerWidth+1)'(1);

   // Next state for one tick, then the pin actions of a new interval.
   always_comb begin
      spi_mode_in    = spi_mode_ff;
      half_period_in = half_period_ff;
      tx_shift_in    = tx_shift_ff;
      rx_shift_in    = rx_shift_ff;
      bit_index_in   = bit_index_ff;
      phase_in       = phase_ff;
      tick_count_in  = tick_count_ff;
      sck_in         = sck_ff;
      mosi_in        = mosi_ff;
      cs_in          = cs_ff;
      busy_in        = busy_ff;
      sel_delay_in   = sel_delay_ff;
      start_en       = 1'b0;
      rejected       = 1'b0;
      rx_valid       = 1'b0;
      rx_out         = '0;
      phase_step     = '0;
      bit_step       = '0;

      if (step) begin
         if (busy_ff) begin
            rejected = cmd_valid;
            if (tick_next >= {1'b0, half_period_eff}) begin
               tick_count_in = '0;
               if (sel_delay_ff) begin
                  sel_delay_in = 1'b0;
                  busy_in      = 1'b0;
               end else begin
                  phase_step = {1'b0, phase_ff} + 3'd1;
                  bit_step   = {1'b0, bit_index_ff};
                  if (phase_step >= 3'd3) begin
                     phase_step = '0;
                     bit_step   = bit_step + 4'd1;
                  end
                  phase_in = phase_step[1:0];
                  if (bit_step[3]) begin
                     // Last interval of the byte has run out.
                     bit_index_in = '0;
                     busy_in      = 1'b0;
                     rx_valid     = 1'b1;
                     rx_out       = rx_shift_ff;
                  end else begin
                     bit_index_in = bit_step[2:0];
                     start_en     = 1'b1;
                  end
               end
            end else begin
               tick_count_in = tick_next[DividerWidth-1:0];
            end
         end else if ((item.opcode == OP_EXCHANGE) || (item.opcode == OP_READ)) begin
            tx_shift_in   = (item.opcode == OP_EXCHANGE) ? item.tx_byte : READ_FILL;
            rx_shift_in   = '0;
            bit_index_in  = '0;
            phase_in      = PHASE_FIRST;
            tick_count_in = '0;
            busy_in       = 1'b1;
            sel_delay_in  = 1'b0;
            start_en      = 1'b1;
         end else if ((item.opcode == OP_SELECT) || (item.opcode == OP_DESELECT)) begin
            cs_in         = (item.opcode == OP_DESELECT);
            tick_count_in = '0;
            busy_in       = 1'b1;
            sel_delay_in  = 1'b1;
         end
      end

      // Pin actions at the first tick of an interval.
      if (start_en) begin
         case (phase_in)
            PHASE_FIRST: begin
               mosi_in     = tx_shift_in[7];
               tx_shift_in = {tx_shift_in[6:0], 1'b0};
               if (cpha) sck_in = ~cpol;
            end
            PHASE_SECOND: begin
               sck_in = cpha ? cpol : ~cpol;
            end
            default: begin
               rx_shift_in = {rx_shift_in[6:0], item.miso};
               if (!cpha) sck_in = cpol;
            end
         endcase
      end

      // Register writes; a mode write while idle parks SCK at the new level.
      if (csr.write) begin
         if (csr.index == CSR_SPI_MODE) begin
            spi_mode_in = csr.data[1:0];
            if (!busy_ff) sck_in = csr.data[1];
         end else if (csr.index == CSR_HALF_PERIOD) begin
            half_period_in = csr.data;
         end
      end
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         spi_mode_ff    <= '0;
         half_period_ff <= HalfPeriodReset;
         tx_shift_ff    <= '0;
         rx_shift_ff    <= '0;
         bit_index_ff   <= '0;
         phase_ff       <= PHASE_FIRST;
         tick_count_ff  <= '0;
         sck_ff         <= 1'b0;
         mosi_ff        <= 1'b0;
         cs_ff          <= 1'b1;
         busy_ff        <= 1'b0;
         sel_delay_ff   <= 1'b0;
      end else begin
         spi_mode_ff    <= spi_mode_in;
         half_period_ff <= half_period_in;
         tx_shift_ff    <= tx_shift_in;
         rx_shift_ff    <= rx_shift_in;
         bit_index_ff   <= bit_index_in;
         phase_ff       <= phase_in;
         tick_count_ff  <= tick_count_in;
         sck_ff         <= sck_in;
         mosi_ff        <= mosi_in;
         cs_ff          <= cs_in;
         busy_ff        <= busy_in;
         sel_delay_ff   <= sel_delay_in;
      end
   end

   // Result of the tick being consumed.
   always_comb begin
      result.sck      = sck_in;
      result.mosi     = mosi_in;
      result.cs_n     = cs_in;
      result.rx_byte  = rx_out;
      result.rx_valid = rx_valid;
      result.busy_res = busy_in;
      result.rejected = rejected;
   end

endmodule

/* rtl/spi_master_byte_shifter_core.sv */
// Top level of the tick-driven SPI master: input register, engine, result
// register and configuration port. Uses spims_pkg and spims_engine.
//
//  channel | direction | handshake            | payload
//  req     | in        | req_tvalid/tready    | req_tdata: opcode, tx_byte, miso
//  rsp     | out       | rsp_tvalid/tready    | rsp_tdata: pins, rx byte, status
//  csr     | in        | csr_valid/csr_ready  | csr_index, csr_data
//
// One word per cycle while the result is not stalled: a word is held in the
// input register, the engine consumes it combinationally and its result is
// registered in the result register, from which it is offered on rsp.
// Reset is synchronous; it restores the mode, the interval length (50) and
// the pin levels. A stalled result holds the pipe; csr_ready is always high.
module spi_master_byte_shifter_core import spims_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [15:0]              req_tdata,   // opcode[2:0], tx_byte[10:3], miso[11]
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [15:0]              rsp_tdata,   // sck[0], mosi[1], cs_n[2], rx_byte[10:3],
                                                 // rx_valid[11], busy_res[12], rejected[13]
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [DividerWidth-1:0]  csr_data
);

   logic          in_valid_ff;
   req_item_type  in_item_ff;
   logic          out_valid_ff;
   rsp_item_type  out_item_ff;
   logic          advance;
   rsp_item_type  step_result;
   csr_write_type csr_write;

   // The engine consumes the held word whenever the result register is free.
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign csr_ready  = 1'b1;

   assign csr_write.write = csr_valid;
   assign csr_write.index = csr_index;
   assign csr_write.data  = csr_data;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_item_ff.opcode  <= req_tdata[2:0];
         in_item_ff.tx_byte <= req_tdata[10:3];
         in_item_ff.miso    <= req_tdata[11];
      end
   end

   spims_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (in_item_ff),
      .csr    (csr_write),
      .result (step_result)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_item_ff <= step_result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00, out_item_ff.rejected, out_item_ff.busy_res,
                        out_item_ff.rx_valid, out_item_ff.rx_byte, out_item_ff.cs_n,
                        out_item_ff.mosi, out_item_ff.sck};

endmodule
